// File: rtl/u8cp_pkg.sv
// u8cp_pkg: types and constants shared by the utf-8 to code point decoder
// no dependencies; compile first

package u8cp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POINT_W = 21;
    localparam int unsigned OWED_W  = 2;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [POINT_W-1:0] point_t;
    typedef logic [OWED_W-1:0]  owed_t;

    // lead byte classes
    localparam byte_t LEAD1_MASK  = 8'h80;
    localparam byte_t LEAD1_MATCH = 8'h00;
    localparam byte_t LEAD2_MASK  = 8'hE0;
    localparam byte_t LEAD2_MATCH = 8'hC0;
    localparam byte_t LEAD3_MASK  = 8'hF0;
    localparam byte_t LEAD3_MATCH = 8'hE0;
    localparam byte_t LEAD4_MASK  = 8'hF8;
    localparam byte_t LEAD4_MATCH = 8'hF0;

    // payload bits carried by each byte kind
    localparam byte_t CONT_BITS  = 8'h3F;
    localparam byte_t LEAD2_BITS = 8'h1F;
    localparam byte_t LEAD3_BITS = 8'h0F;
    localparam byte_t LEAD4_BITS = 8'h07;

    // continuation counts
    localparam owed_t OWED_NONE  = 2'd0;
    localparam owed_t OWED_ONE   = 2'd1;
    localparam owed_t OWED_TWO   = 2'd2;
    localparam owed_t OWED_THREE = 2'd3;

    // result of one decode step
    typedef struct packed {
        logic   emit;
        point_t code_point;
        logic   ends_text;
        owed_t  owed_next;
        point_t partial_next;
    } step_t;

endpackage

// File: rtl/u8cp_if.sv
// u8cp_byte_if and u8cp_point_if: valid/ready channels of the decoder
// depends on u8cp_pkg

interface u8cp_byte_if;
    logic            valid;
    logic            ready;
    u8cp_pkg::byte_t text_byte;
    logic            is_final_byte;

    modport source (output valid, output text_byte, output is_final_byte, input ready);
    modport sink   (input valid, input text_byte, input is_final_byte, output ready);
endinterface

interface u8cp_point_if;
    logic             valid;
    logic             ready;
    u8cp_pkg::point_t code_point;
    logic             ends_text;

    modport source (output valid, output code_point, output ends_text, input ready);
    modport sink   (input valid, input code_point, input ends_text, output ready);
endinterface

// File: rtl/u8cp_decode.sv
// u8cp_decode: one combinational decode step of a utf-8 byte against the
// sequence state; depends on u8cp_pkg

module u8cp_decode
(
    input  u8cp_pkg::byte_t  text_byte,
    input  logic             is_final_byte,
    input  u8cp_pkg::owed_t  owed,
    input  u8cp_pkg::point_t partial,
    output u8cp_pkg::step_t  step
);

    u8cp_pkg::point_t cont_bits;
    u8cp_pkg::point_t acc;
    u8cp_pkg::owed_t  owed_left;
    logic             emit_now;
    logic             drop;

    // continuation bits placed by how many bytes are still owed
    always_comb
    begin
        case (owed)
            u8cp_pkg::OWED_THREE:
                cont_bits = {3'b000, text_byte[5:0], 12'h000};
            u8cp_pkg::OWED_TWO:
                cont_bits = {9'h000, text_byte[5:0], 6'h00};
            default:
                cont_bits = {15'h0000, text_byte[5:0]};
        endcase
    end

    // classify byte and gather bits
    always_comb
    begin
        acc       = partial;
        owed_left = u8cp_pkg::OWED_NONE;
        emit_now  = 1'b0;
        drop      = 1'b0;
        if (owed != u8cp_pkg::OWED_NONE)
        begin
            acc       = partial | cont_bits;
            owed_left = owed - u8cp_pkg::OWED_ONE;
            emit_now  = (owed_left == u8cp_pkg::OWED_NONE);
        end
        else if ((text_byte & u8cp_pkg::LEAD1_MASK) == u8cp_pkg::LEAD1_MATCH)
        begin
            acc      = {13'h0000, text_byte};
            emit_now = 1'b1;
        end
        else if ((text_byte & u8cp_pkg::LEAD2_MASK) == u8cp_pkg::LEAD2_MATCH)
        begin
            acc       = {10'h000, text_byte[4:0], 6'h00};
            owed_left = u8cp_pkg::OWED_ONE;
        end
        else if ((text_byte & u8cp_pkg::LEAD3_MASK) == u8cp_pkg::LEAD3_MATCH)
        begin
            acc       = {5'h00, text_byte[3:0], 12'h000};
            owed_left = u8cp_pkg::OWED_TWO;
        end
        else if ((text_byte & u8cp_pkg::LEAD4_MASK) == u8cp_pkg::LEAD4_MATCH)
        begin
            acc       = {text_byte[2:0], 18'h00000};
            owed_left = u8cp_pkg::OWED_THREE;
        end
        else
        begin
            drop = 1'b1;
        end
    end

    // text ending inside a sequence flushes the partial point
    always_comb
    begin
        step.emit       = !drop && (emit_now ||
                          (is_final_byte && owed_left != u8cp_pkg::OWED_NONE));
        step.code_point = acc;
        step.ends_text  = is_final_byte;
        if (drop || step.emit)
        begin
            step.owed_next    = u8cp_pkg::OWED_NONE;
            step.partial_next = '0;
        end
        else
        begin
            step.owed_next    = owed_left;
            step.partial_next = acc;
        end
    end

endmodule

// File: rtl/utf8_to_codepoint_decoder.sv
// utf8_to_codepoint_decoder: utf-8 bytes in, 21-bit code points out
// a byte taken into the input register goes through the combinational decode
// step; a code point it completes enters the result register as the byte moves
// on; one byte per cycle unless a full result register is not being drained
// reset: rst_n clears the sequence state and both valid flags at once
// depends on u8cp_pkg, u8cp_byte_if, u8cp_point_if, u8cp_decode

module utf8_to_codepoint_decoder
(
    input  logic                clk,
    input  logic                rst_n,
    u8cp_byte_if.sink           byte_chan,
    u8cp_point_if.source        point_chan
);

    logic             stage_valid_reg;
    u8cp_pkg::byte_t  stage_byte_reg;
    logic             stage_last_reg;
    u8cp_pkg::owed_t  owed_reg;
    u8cp_pkg::point_t partial_reg;
    logic             out_valid_reg;
    u8cp_pkg::point_t out_point_reg;
    logic             out_last_reg;
    u8cp_pkg::step_t  step;
    logic             advance;
    logic             take_beat;

    // the staged byte moves on whenever the result register is free or draining
    assign advance   = stage_valid_reg && (!out_valid_reg || point_chan.ready);
    assign take_beat = byte_chan.valid && byte_chan.ready;

    assign byte_chan.ready = !stage_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (byte_chan.ready)
        begin
            stage_valid_reg <= byte_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_beat)
        begin
            stage_byte_reg <= byte_chan.text_byte;
            stage_last_reg <= byte_chan.is_final_byte;
        end
    end

    // decode step
    u8cp_decode u_decode
    (
        .text_byte     (stage_byte_reg),
        .is_final_byte (stage_last_reg),
        .owed          (owed_reg),
        .partial       (partial_reg),
        .step          (step)
    );

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg    <= u8cp_pkg::OWED_NONE;
            partial_reg <= '0;
        end
        else if (advance)
        begin
            owed_reg    <= step.owed_next;
            partial_reg <= step.partial_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step.emit;
        end
        else if (point_chan.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step.emit)
        begin
            out_point_reg <= step.code_point;
            out_last_reg  <= step.ends_text;
        end
    end

    assign point_chan.valid      = out_valid_reg;
    assign point_chan.code_point = out_point_reg;
    assign point_chan.ends_text  = out_last_reg;

    // final byte always leaves a clean state for the next text
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && stage_last_reg |=> owed_reg == u8cp_pkg::OWED_NONE && partial_reg == '0)
        else $error("state not cleared after final byte");

    // no bits gathered while nothing is owed
    a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
        owed_reg == u8cp_pkg::OWED_NONE |-> partial_reg == '0)
        else $error("partial point held with no bytes owed");

    // an empty result register never stalls the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> byte_chan.ready)
        else $error("input stalled with result register empty");

endmodule
